@@ hw/rtl/dhc_pkg.sv @@
// dhc_pkg: shared types and constants of the datagram header checker.
// Beat structs for both channels, config struct, result-push struct, error codes.
// No dependencies.
package dhc_pkg;

   localparam logic [2:0] ERR_OK      = 3'd0;
   localparam logic [2:0] ERR_SHORT   = 3'd1;
   localparam logic [2:0] ERR_MAGIC   = 3'd2;
   localparam logic [2:0] ERR_VERSION = 3'd3;
   localparam logic [2:0] ERR_TYPE    = 3'd4;
   localparam logic [2:0] ERR_LENGTH  = 3'd5;

   localparam logic [1:0] CSR_EXPECTED_VERSION = 2'd0;
   localparam logic [1:0] CSR_LOWEST_TYPE      = 2'd1;
   localparam logic [1:0] CSR_HIGHEST_TYPE     = 2'd2;

   localparam logic [7:0] MAGIC_TAB [8] = '{
      8'h4D, 8'h4F, 8'h53, 8'h48, 8'h43, 8'h50, 8'h31, 8'h00
   };

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic        result_kind;
      logic [7:0]  payload_byte;
      logic        accepted;
      logic [2:0]  error_code;
      logic [7:0]  packet_type;
      logic [63:0] xfer_id;
      logic [31:0] blk_id;
      logic [31:0] sym_id;
      logic [31:0] payload_length;
   } rsp_type;

   typedef struct packed {
      logic [7:0] expected_version;
      logic [7:0] lowest_type;
      logic [7:0] highest_type;
   } cfg_type;

   // results produced by one beat: count 0..2, first then second
   typedef struct packed {
      logic [1:0] count;
      rsp_type    first;
      rsp_type    second;
   } push_type;

endpackage

@@ hw/rtl/dhc_parser.sv @@
// dhc_parser: per-packet header state, payload counter and verdict logic.
// Depends on dhc_pkg.
module dhc_parser (
   input  logic             clock,
   input  logic             reset,
   input  logic             fire,
   input  dhc_pkg::req_type beat,
   input  dhc_pkg::cfg_type cfg,
   output dhc_pkg::push_type push
);

   localparam logic [4:0] HDR_LEN   = 5'd30;
   localparam logic [4:0] MAGIC_END = 5'd8;
   localparam logic [4:0] VER_POS   = 5'd8;
   localparam logic [4:0] TYPE_POS  = 5'd9;
   localparam logic [4:0] TID_END   = 5'd18;
   localparam logic [4:0] BID_END   = 5'd22;
   localparam logic [4:0] SID_END   = 5'd26;

   logic [4:0]  pos_ff, pos_in, pos_nxt;
   logic        magic_ff, magic_in, magic_nxt;
   logic [7:0]  ver_ff, ver_in, ver_nxt;
   logic [7:0]  type_ff, type_in, type_nxt;
   logic [63:0] tid_ff, tid_in, tid_nxt;
   logic [31:0] bid_ff, bid_in, bid_nxt;
   logic [31:0] sid_ff, sid_in, sid_nxt;
   logic [31:0] len_ff, len_in, len_nxt;
   logic [31:0] cnt_ff, cnt_in, cnt_nxt;
   logic        hdr;
   logic [7:0]  b;
   logic [2:0]  err;
   dhc_pkg::rsp_type pay_res, ver_res;

   assign b   = beat.data_byte;
   assign hdr = pos_ff < HDR_LEN;

   always_comb begin
      pos_nxt   = pos_ff;
      magic_nxt = magic_ff;
      ver_nxt   = ver_ff;
      type_nxt  = type_ff;
      tid_nxt   = tid_ff;
      bid_nxt   = bid_ff;
      sid_nxt   = sid_ff;
      len_nxt   = len_ff;
      cnt_nxt   = cnt_ff;
      if (hdr) begin
         pos_nxt = pos_ff + 5'd1;
         if (pos_ff < MAGIC_END) begin
            magic_nxt = magic_ff & (b == dhc_pkg::MAGIC_TAB[pos_ff[2:0]]);
         end else if (pos_ff == VER_POS) begin
            ver_nxt = b;
         end else if (pos_ff == TYPE_POS) begin
            type_nxt = b;
         end else if (pos_ff < TID_END) begin
            tid_nxt = {tid_ff[55:0], b};
         end else if (pos_ff < BID_END) begin
            bid_nxt = {bid_ff[23:0], b};
         end else if (pos_ff < SID_END) begin
            sid_nxt = {sid_ff[23:0], b};
         end else begin
            len_nxt = {len_ff[23:0], b};
         end
      end else if (cnt_ff != '1) begin
         cnt_nxt = cnt_ff + 32'd1;
      end
   end

   always_comb begin
      if (pos_nxt < HDR_LEN) begin
         err = dhc_pkg::ERR_SHORT;
      end else if (!magic_nxt) begin
         err = dhc_pkg::ERR_MAGIC;
      end else if (ver_nxt != cfg.expected_version) begin
         err = dhc_pkg::ERR_VERSION;
      end else if (type_nxt < cfg.lowest_type || type_nxt > cfg.highest_type) begin
         err = dhc_pkg::ERR_TYPE;
      end else if (cnt_nxt == '1 || cnt_nxt != len_nxt) begin
         err = dhc_pkg::ERR_LENGTH;
      end else begin
         err = dhc_pkg::ERR_OK;
      end
   end

   always_comb begin
      pay_res              = '0;
      pay_res.payload_byte = b;

      ver_res                = '0;
      ver_res.result_kind    = 1'b1;
      ver_res.accepted       = (err == dhc_pkg::ERR_OK);
      ver_res.error_code     = err;
      ver_res.packet_type    = type_nxt;
      ver_res.xfer_id        = tid_nxt;
      ver_res.blk_id         = bid_nxt;
      ver_res.sym_id         = sid_nxt;
      ver_res.payload_length = len_nxt;

      push.second = ver_res;
      if (hdr) begin
         push.first = ver_res;
         push.count = beat.last_byte ? 2'd1 : 2'd0;
      end else begin
         push.first = pay_res;
         push.count = beat.last_byte ? 2'd2 : 2'd1;
      end
      if (!fire) begin
         push.count = 2'd0;
      end
   end

   always_comb begin
      pos_in   = pos_ff;
      magic_in = magic_ff;
      ver_in   = ver_ff;
      type_in  = type_ff;
      tid_in   = tid_ff;
      bid_in   = bid_ff;
      sid_in   = sid_ff;
      len_in   = len_ff;
      cnt_in   = cnt_ff;
      if (fire) begin
         if (beat.last_byte) begin
            pos_in   = '0;
            magic_in = 1'b1;
            ver_in   = '0;
            type_in  = '0;
            tid_in   = '0;
            bid_in   = '0;
            sid_in   = '0;
            len_in   = '0;
            cnt_in   = '0;
         end else begin
            pos_in   = pos_nxt;
            magic_in = magic_nxt;
            ver_in   = ver_nxt;
            type_in  = type_nxt;
            tid_in   = tid_nxt;
            bid_in   = bid_nxt;
            sid_in   = sid_nxt;
            len_in   = len_nxt;
            cnt_in   = cnt_nxt;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         magic_ff <= 1'b1;
         ver_ff   <= '0;
         type_ff  <= '0;
         tid_ff   <= '0;
         bid_ff   <= '0;
         sid_ff   <= '0;
         len_ff   <= '0;
         cnt_ff   <= '0;
      end else begin
         pos_ff   <= pos_in;
         magic_ff <= magic_in;
         ver_ff   <= ver_in;
         type_ff  <= type_in;
         tid_ff   <= tid_in;
         bid_ff   <= bid_in;
         sid_ff   <= sid_in;
         len_ff   <= len_in;
         cnt_ff   <= cnt_in;
      end
   end

   a_pos_bounded: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= HDR_LEN)
      else $error("header position past header length");

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      fire && beat.last_byte |=> pos_ff == '0 && cnt_ff == '0 && magic_ff)
      else $error("packet state not cleared after last beat");

   a_two_results_order: assert property (@(posedge clock) disable iff (reset)
      push.count == 2'd2 |-> !push.first.result_kind && push.second.result_kind)
      else $error("payload result must precede verdict");

   a_payload_only_after_hdr: assert property (@(posedge clock) disable iff (reset)
      push.count != 2'd0 && !push.first.result_kind |-> pos_ff == HDR_LEN)
      else $error("payload result inside header");

endmodule

@@ hw/rtl/dhc_result_queue.sv @@
// dhc_result_queue: three-slot result buffer between parser and rsp channel.
// Takes up to two results per cycle; head slot drives the output. Depends on dhc_pkg.
module dhc_result_queue (
   input  logic              clock,
   input  logic              reset,
   input  dhc_pkg::push_type push,
   output logic              space,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output dhc_pkg::rsp_type  rsp_data
);

   dhc_pkg::rsp_type slot_ff [3];
   dhc_pkg::rsp_type slot_in [3];
   dhc_pkg::rsp_type shifted [3];
   logic [1:0] cnt_ff, cnt_in;
   logic [1:0] base;
   logic       pop;

   assign pop       = rsp_valid && rsp_ready;
   assign rsp_valid = cnt_ff != 2'd0;
   assign rsp_data  = slot_ff[0];
   // at most one slot held: room for a two-result beat
   assign space     = !cnt_ff[1];
   assign base      = cnt_ff - {1'b0, pop};
   assign cnt_in    = base + push.count;

   always_comb begin
      shifted[0] = pop ? slot_ff[1] : slot_ff[0];
      shifted[1] = pop ? slot_ff[2] : slot_ff[1];
      shifted[2] = slot_ff[2];
      for (int i = 0; i < 3; i++) begin
         slot_in[i] = shifted[i];
         if (push.count != 2'd0 && base == 2'(i)) begin
            slot_in[i] = push.first;
         end
         if (push.count == 2'd2 && base + 2'd1 == 2'(i)) begin
            slot_in[i] = push.second;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         slot_ff[i] <= slot_in[i];
      end
   end

   a_push_has_room: assert property (@(posedge clock) disable iff (reset)
      push.count != 2'd0 |-> !cnt_ff[1])
      else $error("push into full result buffer");

   a_pop_only_drain: assert property (@(posedge clock) disable iff (reset)
      pop && push.count == 2'd0 |=> cnt_ff == $past(cnt_ff) - 2'd1)
      else $error("count wrong after drain");

   a_head_kept: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_data == $past(rsp_data))
      else $error("head slot changed while stalled");

endmodule

@@ hw/rtl/datagram_header_checker.sv @@
// datagram_header_checker: top level; config registers, parser and result buffer.
// Depends on dhc_pkg, dhc_parser, dhc_result_queue.
//
// Usage: packet bytes enter on the req channel, one byte per beat, with
// last_byte set on the final byte. Bytes 0..29 form the header; each later
// byte leaves on the rsp channel as a payload result (result_kind 0). The
// final byte also yields a verdict result (result_kind 1) with error_code,
// accepted and the gathered header fields; a final payload byte gives its
// payload result first, then the verdict.
// Results are registered in the result buffer before they reach rsp.
// Throughput: one beat per cycle while rsp_ready is high; a beat that yields
// two results holds req_ready low until one drains. The rate is set by the
// three-slot result buffer, which admits a beat while at most one result waits.
// Stall: when rsp_ready is low the buffer holds up to three results and
// req_ready drops once two are held. Reset: clears packet state and buffer;
// expected_version is 1, type range 0..255. csr writes are registered; the
// user must make them only while idle, and the block does not enforce this.
module datagram_header_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  dhc_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output dhc_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic [1:0]       csr_index,
   input  logic [7:0]       csr_wdata
);

   dhc_pkg::cfg_type  cfg_ff, cfg_in;
   dhc_pkg::push_type push;
   logic              fire;

   assign fire = req_valid && req_ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            dhc_pkg::CSR_EXPECTED_VERSION: cfg_in.expected_version = csr_wdata;
            dhc_pkg::CSR_LOWEST_TYPE:      cfg_in.lowest_type      = csr_wdata;
            dhc_pkg::CSR_HIGHEST_TYPE:     cfg_in.highest_type     = csr_wdata;
            default:                       cfg_in                  = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.expected_version <= 8'd1;
         cfg_ff.lowest_type      <= 8'd0;
         cfg_ff.highest_type     <= 8'd255;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   dhc_parser u_parser (
      .clock (clock),
      .reset (reset),
      .fire  (fire),
      .beat  (req_data),
      .cfg   (cfg_ff),
      .push  (push)
   );

   dhc_result_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .space     (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

@@ bench/tb_datagram_header_checker.sv @@
`timescale 1ns / 1ps
// tb_datagram_header_checker: self-checking bench for the datagram header checker.
// Streams packets as byte beats, predicts payload and verdict beats, checks rsp in order.
// Depends on dhc_pkg and datagram_header_checker.
module tb_datagram_header_checker;

   localparam int HDR_LEN = 30;
   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_VERDICT = 1'b1;
   localparam logic [1:0] CSR_UNMAPPED = 2'd3;
   localparam int RANDOM_BEATS = 520;
   localparam int RANDOM_PHASES = 8;

   // header flaws, combinable
   localparam int FLAW_NONE    = 0;
   localparam int FLAW_MAGIC   = 1;
   localparam int FLAW_VERSION = 2;
   localparam int FLAW_SHORT   = 4;

   logic             clock;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   dhc_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   dhc_pkg::rsp_type rsp_data;
   logic             csr_we = 1'b0;
   logic [1:0]       csr_index = '0;
   logic [7:0]       csr_wdata = '0;

   dhc_pkg::req_type pending_beats[$];
   dhc_pkg::rsp_type expected_results[$];
   int      beats_queued = 0;
   int      send_idle_pct = 0;
   int      recv_stall_pct = 0;
   int      mismatches = 0;

   // settings the stimulus aims at
   logic [7:0] tgt_version = 8'd1;
   logic [7:0] tgt_lo = 8'd0;
   logic [7:0] tgt_hi = 8'd255;

   // predictor copy of registers and packet state
   logic [7:0]  cfg_version, cfg_lo, cfg_hi;
   logic [4:0]  hdr_pos;
   logic        magic_ok;
   logic [7:0]  ver_seen, type_seen;
   logic [63:0] tid_acc;
   logic [31:0] blk_acc, sym_acc, len_acc, pay_count;

   datagram_header_checker dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("[datagram_header_checker] ERROR");
      $finish;
   end

   task automatic clear_packet();
      hdr_pos = '0;
      magic_ok = 1'b1;
      ver_seen = '0;
      type_seen = '0;
      tid_acc = '0;
      blk_acc = '0;
      sym_acc = '0;
      len_acc = '0;
      pay_count = '0;
   endtask

   task automatic predict_beat(input dhc_pkg::req_type beat);
      dhc_pkg::rsp_type r;
      logic [2:0]       err;
      if (hdr_pos < 5'(HDR_LEN)) begin
         if (hdr_pos < 5'd8) begin
            if (beat.data_byte != dhc_pkg::MAGIC_TAB[hdr_pos[2:0]]) magic_ok = 1'b0;
         end else if (hdr_pos == 5'd8) begin
            ver_seen = beat.data_byte;
         end else if (hdr_pos == 5'd9) begin
            type_seen = beat.data_byte;
         end else if (hdr_pos < 5'd18) begin
            tid_acc = {tid_acc[55:0], beat.data_byte};
         end else if (hdr_pos < 5'd22) begin
            blk_acc = {blk_acc[23:0], beat.data_byte};
         end else if (hdr_pos < 5'd26) begin
            sym_acc = {sym_acc[23:0], beat.data_byte};
         end else begin
            len_acc = {len_acc[23:0], beat.data_byte};
         end
         hdr_pos = hdr_pos + 5'd1;
      end else begin
         r = '0;
         r.result_kind = KIND_PAYLOAD;
         r.payload_byte = beat.data_byte;
         expected_results.insert(expected_results.size(), r);
         if (pay_count != 32'hFFFF_FFFF) pay_count = pay_count + 32'd1;
      end
      if (beat.last_byte) begin
         if (hdr_pos < 5'(HDR_LEN)) err = dhc_pkg::ERR_SHORT;
         else if (!magic_ok) err = dhc_pkg::ERR_MAGIC;
         else if (ver_seen != cfg_version) err = dhc_pkg::ERR_VERSION;
         else if (type_seen < cfg_lo || type_seen > cfg_hi) err = dhc_pkg::ERR_TYPE;
         else if (pay_count == 32'hFFFF_FFFF || pay_count != len_acc)
            err = dhc_pkg::ERR_LENGTH;
         else err = dhc_pkg::ERR_OK;
         r = '0;
         r.result_kind = KIND_VERDICT;
         r.accepted = (err == dhc_pkg::ERR_OK);
         r.error_code = err;
         r.packet_type = type_seen;
         r.xfer_id = tid_acc;
         r.blk_id = blk_acc;
         r.sym_id = sym_acc;
         r.payload_length = len_acc;
         expected_results.insert(expected_results.size(), r);
         clear_packet();
      end
   endtask

   function automatic string describe(input dhc_pkg::rsp_type r);
      return {$sformatf("kind %0d byte %02h acc %0d err %0d type %02h ",
                        r.result_kind, r.payload_byte, r.accepted, r.error_code,
                        r.packet_type),
              $sformatf("tid %016h blk %08h sym %08h len %08h",
                        r.xfer_id, r.blk_id, r.sym_id, r.payload_length)};
   endfunction

   task automatic check_result(input dhc_pkg::rsp_type got);
      dhc_pkg::rsp_type want;
      if (expected_results.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) $display("unexpected rsp beat at %0t: %s", $time, describe(got));
         return;
      end
      want = expected_results.pop_front();
      if (got.result_kind !== want.result_kind || got.payload_byte !== want.payload_byte ||
          got.accepted !== want.accepted || got.error_code !== want.error_code ||
          got.packet_type !== want.packet_type || got.xfer_id !== want.xfer_id ||
          got.blk_id !== want.blk_id || got.sym_id !== want.sym_id ||
          got.payload_length !== want.payload_length) begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("rsp mismatch at %0t", $time);
            $display("  expected %s", describe(want));
            $display("  actual   %s", describe(got));
         end
      end
   endtask

   // driver: next beat only once the current one is taken
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_valid <= 1'b1;
            req_data <= pending_beats.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      rsp_ready <= !reset && ($urandom_range(99) >= recv_stall_pct);
   end

   // monitor: tracks csr writes, predicts on accepted req beats, checks rsp beats
   always @(posedge clock) begin
      if (reset) begin
         cfg_version = 8'd1;
         cfg_lo = 8'd0;
         cfg_hi = 8'd255;
         clear_packet();
      end else begin
         if (csr_we) begin
            case (csr_index)
               dhc_pkg::CSR_EXPECTED_VERSION: cfg_version = csr_wdata;
               dhc_pkg::CSR_LOWEST_TYPE:      cfg_lo = csr_wdata;
               dhc_pkg::CSR_HIGHEST_TYPE:     cfg_hi = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && req_ready) predict_beat(req_data);
         if (rsp_valid && rsp_ready) check_result(rsp_data);
      end
   end

   task automatic write_csr(input logic [1:0] idx, input logic [7:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         dhc_pkg::CSR_EXPECTED_VERSION: tgt_version = val;
         dhc_pkg::CSR_LOWEST_TYPE:      tgt_lo = val;
         dhc_pkg::CSR_HIGHEST_TYPE:     tgt_hi = val;
         default: ;
      endcase
   endtask

   task automatic set_config(input logic [7:0] ver, input logic [7:0] lo, input logic [7:0] hi);
      write_csr(dhc_pkg::CSR_EXPECTED_VERSION, ver);
      write_csr(dhc_pkg::CSR_LOWEST_TYPE, lo);
      write_csr(dhc_pkg::CSR_HIGHEST_TYPE, hi);
   endtask

   task automatic wait_idle();
      while (pending_beats.size() != 0 || req_valid || expected_results.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // a short packet keeps only n_pay bytes
   task automatic queue_packet(input int flaws, input int n_pay, input logic [7:0] typ,
                               input logic [63:0] tid, input logic [31:0] blk,
                               input logic [31:0] sym, input logic [31:0] decl);
      logic [7:0]       pkt[$];
      int               keep;
      int               k;
      dhc_pkg::req_type beat;
      for (k = 0; k < 8; k++) pkt.insert(pkt.size(), dhc_pkg::MAGIC_TAB[k]);
      if ((flaws & FLAW_MAGIC) != 0) begin
         k = $urandom_range(7);
         pkt[k] = pkt[k] ^ 8'($urandom_range(255, 1));
      end
      if ((flaws & FLAW_VERSION) != 0)
         pkt.insert(pkt.size(), tgt_version ^ 8'($urandom_range(255, 1)));
      else pkt.insert(pkt.size(), tgt_version);
      pkt.insert(pkt.size(), typ);
      for (k = 56; k >= 0; k -= 8) pkt.insert(pkt.size(), tid[k +: 8]);
      for (k = 24; k >= 0; k -= 8) pkt.insert(pkt.size(), blk[k +: 8]);
      for (k = 24; k >= 0; k -= 8) pkt.insert(pkt.size(), sym[k +: 8]);
      for (k = 24; k >= 0; k -= 8) pkt.insert(pkt.size(), decl[k +: 8]);
      for (k = 0; k < n_pay; k++) pkt.insert(pkt.size(), 8'($urandom));
      keep = ((flaws & FLAW_SHORT) != 0) ? n_pay : pkt.size();
      for (k = 0; k < keep; k++) begin
         beat.data_byte = pkt[k];
         beat.last_byte = (k == keep - 1);
         pending_beats.insert(pending_beats.size(), beat);
      end
      beats_queued += keep;
   endtask

   task automatic queue_noise(input int n);
      dhc_pkg::req_type beat;
      int               k;
      for (k = 0; k < n; k++) begin
         beat.data_byte = 8'($urandom);
         beat.last_byte = (k == n - 1);
         pending_beats.insert(pending_beats.size(), beat);
      end
      beats_queued += n;
   endtask

   task automatic random_packet();
      int          roll;
      int          n;
      logic [7:0]  typ;
      logic [31:0] decl;
      roll = $urandom_range(99);
      n = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(6);
      if (tgt_lo <= tgt_hi) typ = 8'($urandom_range(tgt_hi, tgt_lo));
      else typ = 8'($urandom);
      decl = n;
      if (roll >= 74 && roll < 80) begin
         if (tgt_lo > 8'd0) typ = 8'($urandom_range(tgt_lo - 8'd1, 0));
         else if (tgt_hi < 8'd255) typ = 8'($urandom_range(255, tgt_hi + 8'd1));
      end
      if (roll >= 80 && roll < 88) begin
         if ($urandom_range(1) == 0) decl = n + $urandom_range(3, 1);
         else decl = $urandom;
      end
      if (roll < 60 || (roll >= 74 && roll < 88))
         queue_packet(FLAW_NONE, n, typ, {$urandom, $urandom}, $urandom, $urandom, decl);
      else if (roll < 68)
         queue_packet(FLAW_MAGIC, n, typ, {$urandom, $urandom}, $urandom, $urandom, decl);
      else if (roll < 74)
         queue_packet(FLAW_VERSION, n, typ, {$urandom, $urandom}, $urandom, $urandom, decl);
      else if (roll < 94)
         queue_packet(FLAW_SHORT | ($urandom_range(1) ? FLAW_MAGIC : FLAW_NONE),
                      $urandom_range(HDR_LEN - 1, 1), typ, {$urandom, $urandom},
                      $urandom, $urandom, decl);
      else
         queue_noise($urandom_range(40, 1));
   endtask

   initial begin
      int          ph;
      int          k;
      logic [7:0]  lo;
      logic [7:0]  hi;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      // directed: reset settings
      queue_packet(FLAW_SHORT, 1, 8'h00, '0, '0, '0, '0);
      queue_packet(FLAW_NONE, 0, 8'h00, '1, '0, '1, 32'd0);
      queue_packet(FLAW_NONE, 3, 8'hFF, '0, '1, '0, 32'd3);
      queue_packet(FLAW_NONE, 2, 8'h80, 64'h0123_4567_89AB_CDEF, 32'h89AB_CDEF,
                   32'h0123_4567, 32'hFFFF_FFFF);
      queue_packet(FLAW_MAGIC, 1, 8'h11, '1, '1, '1, 32'd1);
      queue_packet(FLAW_VERSION, 0, 8'h22, '0, '0, '0, 32'd0);
      queue_packet(FLAW_SHORT | FLAW_MAGIC | FLAW_VERSION, HDR_LEN - 1, 8'h33,
                   '1, '1, '1, '1);
      wait_idle();
      write_csr(CSR_UNMAPPED, 8'h55);
      queue_packet(FLAW_NONE, 1, 8'h44, '0, '0, '0, 32'd1);
      wait_idle();

      // narrow type range, version 0
      set_config(8'd0, 8'd10, 8'd20);
      queue_packet(FLAW_NONE, 1, 8'd10, '0, '0, '0, 32'd1);
      queue_packet(FLAW_NONE, 0, 8'd20, '0, '0, '0, 32'd0);
      queue_packet(FLAW_NONE, 0, 8'd9, '0, '0, '0, 32'd0);
      queue_packet(FLAW_NONE, 0, 8'd21, '0, '0, '0, 32'd5);
      queue_packet(FLAW_MAGIC | FLAW_VERSION, 0, 8'd30, '0, '0, '0, 32'd7);
      queue_packet(FLAW_VERSION, 0, 8'd30, '0, '0, '0, 32'd7);
      wait_idle();

      // empty type range
      set_config(8'd255, 8'd255, 8'd0);
      queue_packet(FLAW_NONE, 0, 8'd0, '0, '0, '0, 32'd0);
      queue_packet(FLAW_NONE, 1, 8'd255, '0, '0, '0, 32'd1);
      wait_idle();
      set_config(8'd255, 8'd255, 8'd255);
      queue_packet(FLAW_NONE, 0, 8'd255, '0, '0, '0, 32'd0);
      wait_idle();
      set_config(8'd128, 8'd0, 8'd0);
      queue_packet(FLAW_NONE, 2, 8'd0, '0, '0, '0, 32'd2);

      for (ph = 0; ph < RANDOM_PHASES; ph++) begin
         wait_idle();
         case (ph % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 70; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 70; end
            default: begin send_idle_pct = 13; recv_stall_pct = 13; end
         endcase
         lo = 8'($urandom_range(255));
         hi = 8'($urandom_range(255, lo));
         if (ph == 0) begin
            lo = 8'd0;
            hi = 8'd255;
         end else if (ph == 5) begin
            lo = 8'd200;
            hi = 8'd100;
         end
         set_config(8'($urandom), lo, hi);
         beats_queued = 0;
         while (beats_queued < RANDOM_BEATS / RANDOM_PHASES) random_packet();
      end

      while (pending_beats.size() != 0 || req_valid) @(posedge clock);
      for (k = 0; k < 2000 && expected_results.size() != 0; k++) @(posedge clock);
      repeat (10) @(posedge clock);
      if (expected_results.size() != 0) begin
         mismatches++;
         $display("%0d expected rsp beats never arrived", expected_results.size());
      end
      if (mismatches == 0) begin
         $display("[datagram_header_checker] OK");
      end else begin
         $display("[datagram_header_checker] ERROR");
      end
      $finish;
   end

endmodule
